### sv/circle_time_to_collision_core_macros.svh
// assertion macros for the circle time-to-collision block
// needs clk and rst_n in the scope where a macro is used
`ifndef CIRCLE_TIME_TO_COLLISION_CORE_MACROS_SVH
`define CIRCLE_TIME_TO_COLLISION_CORE_MACROS_SVH

// checked only outside reset
`define CTC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define CTC_ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/ctc_pkg.sv
// shared constants, status codes and types of the time-to-collision block
// no dependencies
package ctc_pkg;

  localparam int POS_WIDTH_DEF = 24;
  localparam int VEL_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF = 8;
  localparam int RAD_WIDTH     = 20;
  localparam int TIME_WIDTH    = 24;
  localparam int STATUS_WIDTH  = 3;
  localparam int QUEUE_DEPTH   = 4;

  typedef logic [STATUS_WIDTH-1:0] status_t;

  localparam status_t ST_HIT     = 3'd0;
  localparam status_t ST_OVERLAP = 3'd1;
  localparam status_t ST_MISS    = 3'd2;
  localparam status_t ST_RECEDE  = 3'd3;
  localparam status_t ST_STILL   = 3'd4;

  // queue state seen by the front and back halves
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic int max_int(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

endpackage

### sv/ctc_in_if.sv
// input channel: one pair of circles per transfer
// depends on ctc_pkg
interface ctc_in_if import ctc_pkg::*; #(
  parameter int POS_WIDTH = POS_WIDTH_DEF,
  parameter int VEL_WIDTH = VEL_WIDTH_DEF
) ();
  logic                        valid;
  logic                        ready;
  logic signed [POS_WIDTH-1:0] pos_a_x;
  logic signed [POS_WIDTH-1:0] pos_a_y;
  logic signed [VEL_WIDTH-1:0] vel_a_x;
  logic signed [VEL_WIDTH-1:0] vel_a_y;
  logic [RAD_WIDTH-1:0]        radius_a;
  logic signed [POS_WIDTH-1:0] pos_b_x;
  logic signed [POS_WIDTH-1:0] pos_b_y;
  logic signed [VEL_WIDTH-1:0] vel_b_x;
  logic signed [VEL_WIDTH-1:0] vel_b_y;
  logic [RAD_WIDTH-1:0]        radius_b;

  modport source (
    output valid, pos_a_x, pos_a_y, vel_a_x, vel_a_y, radius_a,
    output pos_b_x, pos_b_y, vel_b_x, vel_b_y, radius_b,
    input  ready
  );
  modport sink (
    input  valid, pos_a_x, pos_a_y, vel_a_x, vel_a_y, radius_a,
    input  pos_b_x, pos_b_y, vel_b_x, vel_b_y, radius_b,
    output ready
  );
endinterface

### sv/ctc_out_if.sv
// result channel: contact time and status per transfer
// depends on ctc_pkg
interface ctc_out_if import ctc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [TIME_WIDTH-1:0] contact_time;
  status_t               status;

  modport source (output valid, contact_time, status, input ready);
  modport sink (input valid, contact_time, status, output ready);
endinterface

### sv/circle_time_to_collision_core.sv
// Time to first contact of two moving circles.
// Input channel in_ch carries one pair of circles per transfer (positions Q16.8,
// velocities Q8.8, radii Q12.8); out_ch returns one result per pair, in order:
// contact_time (Q16.8, saturated, zero unless status is hit) and status
// (hit, overlapping, miss, receding, no relative motion).
// Throughput: one pair per cycle, sustained while out_ch is ready.
// Pipeline from an input transfer to its result: 6 front stages, one queue
// slot, one square-root stage per root bit, one denominator stage and 25
// divide stages.
// Reset (rst_n low, synchronous) empties the pipeline and the queue; in_ch is
// ready again on the first cycle after reset.
// When out_ch stalls, the back pipeline holds; the four-entry queue then fills
// and the front pipeline stops, which drops in_ch.ready. No item is lost.
// Depends on ctc_pkg, the channel interfaces, ctc_front, ctc_fifo and ctc_back.
module circle_time_to_collision_core import ctc_pkg::*; #(
  parameter int POS_WIDTH = POS_WIDTH_DEF,
  parameter int VEL_WIDTH = VEL_WIDTH_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  ctc_in_if.sink     in_ch,
  ctc_out_if.source  out_ch
);
  localparam int PVW = POS_WIDTH + VEL_WIDTH + 1;
  localparam int CW  = 2 * POS_WIDTH + 1;
  localparam int DW  = 2 * PVW;
  localparam int QW  = STATUS_WIDTH + 1 + DW + PVW + CW;

  q_stat_t        qs;
  logic           push, pop;
  status_t        cls_status, hd_status;
  logic           cls_go, hd_go;
  logic [DW-1:0]  cls_d, hd_d;
  logic [PVW-1:0] cls_pvm, hd_pvm;
  logic [CW-1:0]  cls_c, hd_c;
  logic [QW-1:0]  q_din, q_dout;

  ctc_front #(.POS_WIDTH(POS_WIDTH), .VEL_WIDTH(VEL_WIDTH)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .pos_a_x    (in_ch.pos_a_x),
    .pos_a_y    (in_ch.pos_a_y),
    .vel_a_x    (in_ch.vel_a_x),
    .vel_a_y    (in_ch.vel_a_y),
    .radius_a   (in_ch.radius_a),
    .pos_b_x    (in_ch.pos_b_x),
    .pos_b_y    (in_ch.pos_b_y),
    .vel_b_x    (in_ch.vel_b_x),
    .vel_b_y    (in_ch.vel_b_y),
    .radius_b   (in_ch.radius_b),
    .qs         (qs),
    .push       (push),
    .cls_status (cls_status),
    .cls_go     (cls_go),
    .cls_d      (cls_d),
    .cls_pvm    (cls_pvm),
    .cls_c      (cls_c)
  );

  assign q_din = {cls_status, cls_go, cls_d, cls_pvm, cls_c};
  assign {hd_status, hd_go, hd_d, hd_pvm, hd_c} = q_dout;

  ctc_fifo #(.W(QW)) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (q_din),
    .pop   (pop),
    .dout  (q_dout),
    .qs    (qs)
  );

  ctc_back #(
    .POS_WIDTH (POS_WIDTH),
    .VEL_WIDTH (VEL_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .qs           (qs),
    .pop          (pop),
    .hd_status    (hd_status),
    .hd_go        (hd_go),
    .hd_d         (hd_d),
    .hd_pvm       (hd_pvm),
    .hd_c         (hd_c),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .contact_time (out_ch.contact_time),
    .status       (out_ch.status)
  );
endmodule

### sv/ctc_wmul.sv
// two-stage wide multiplier built from four half-width partial products
// depends on nothing but its parameters
module ctc_wmul #(
  parameter int AW = 32,
  parameter int BW = 32
) (
  input  logic             clk,
  input  logic             en,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic [AW+BW-1:0] p
);
  localparam int AL = (AW + 1) / 2;
  localparam int AH = AW - AL;
  localparam int BL = (BW + 1) / 2;
  localparam int BH = BW - BL;
  localparam int PW = AW + BW;

  logic [AL+BL-1:0] p_ll_r;
  logic [AL+BH-1:0] p_lh_r;
  logic [AH+BL-1:0] p_hl_r;
  logic [AH+BH-1:0] p_hh_r;

  always_ff @(posedge clk) begin
    if (en) begin
      p_ll_r <= a[AL-1:0] * b[BL-1:0];
      p_lh_r <= a[AL-1:0] * b[BW-1:BL];
      p_hl_r <= a[AW-1:AL] * b[BL-1:0];
      p_hh_r <= a[AW-1:AL] * b[BW-1:BL];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p <= (PW'(p_hh_r) << (AL + BL)) + (PW'(p_hl_r) << AL)
         + (PW'(p_lh_r) << BL) + PW'(p_ll_r);
    end
  end
endmodule

### sv/ctc_front.sv
// front half: relative motion, dot products, discriminant and classification
// depends on ctc_pkg and ctc_wmul
module ctc_front import ctc_pkg::*; #(
  parameter int POS_WIDTH = POS_WIDTH_DEF,
  parameter int VEL_WIDTH = VEL_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [POS_WIDTH-1:0]           pos_a_x,
  input  logic signed [POS_WIDTH-1:0]           pos_a_y,
  input  logic signed [VEL_WIDTH-1:0]           vel_a_x,
  input  logic signed [VEL_WIDTH-1:0]           vel_a_y,
  input  logic [RAD_WIDTH-1:0]                  radius_a,
  input  logic signed [POS_WIDTH-1:0]           pos_b_x,
  input  logic signed [POS_WIDTH-1:0]           pos_b_y,
  input  logic signed [VEL_WIDTH-1:0]           vel_b_x,
  input  logic signed [VEL_WIDTH-1:0]           vel_b_y,
  input  logic [RAD_WIDTH-1:0]                  radius_b,
  input  q_stat_t                               qs,
  output logic                                  push,
  output status_t                               cls_status,
  output logic                                  cls_go,
  output logic [2*(POS_WIDTH+VEL_WIDTH+1)-1:0]  cls_d,
  output logic [POS_WIDTH+VEL_WIDTH:0]          cls_pvm,
  output logic [2*POS_WIDTH:0]                  cls_c
);
  localparam int DPW  = POS_WIDTH + 1;
  localparam int DVW  = VEL_WIDTH + 1;
  localparam int RSW  = RAD_WIDTH + 1;
  localparam int SQPW = 2 * POS_WIDTH;
  localparam int SQVW = 2 * VEL_WIDTH;
  localparam int PPW  = 2 * POS_WIDTH + 1;
  localparam int VVW  = 2 * VEL_WIDTH + 1;
  localparam int PVSW = POS_WIDTH + VEL_WIDTH + 2;
  localparam int PVW  = POS_WIDTH + VEL_WIDTH + 1;
  localparam int RRW  = 2 * RSW;
  localparam int CW   = PPW;
  localparam int DW   = 2 * PVW;
  localparam int VCW  = VVW + CW;
  localparam int CMPW = max_int(PPW, RRW);
  localparam int DCW  = max_int(DW, VCW);

  logic fe;

  // stage 1: relative position, velocity and radius sum
  logic                   v1_r;
  logic signed [DPW-1:0]  px1_r, py1_r;
  logic signed [DVW-1:0]  vx1_r, vy1_r;
  logic [RSW-1:0]         rs1_r;

  // stage 2: products
  logic                   v2_r;
  logic [SQPW-1:0]        sqpx2_r, sqpy2_r;
  logic [SQVW-1:0]        sqvx2_r, sqvy2_r;
  logic signed [PVSW-1:0] pvx2_r, pvy2_r;
  logic [RRW-1:0]         rr2_r;
  logic signed [2*DPW-1:0] sqpx_c, sqpy_c;
  logic signed [2*DVW-1:0] sqvx_c, sqvy_c;
  logic signed [PVSW-1:0]  pvx_c, pvy_c;
  logic [RRW-1:0]          rr_c;

  // stage 3: sums
  logic                   v3_r;
  logic [PPW-1:0]         pp3_r;
  logic [VVW-1:0]         vv3_r;
  logic signed [PVSW-1:0] pv3_r;
  logic [RRW-1:0]         rr3_r;

  // stage 4: c, |pv| and flags
  logic                   v4_r;
  logic                   ovl4_r, pvneg4_r, vvz4_r, cz4_r;
  logic [CW-1:0]          c4_r;
  logic [PVW-1:0]         pvm4_r;
  logic [VVW-1:0]         vv4_r;

  // stages 5 and 6: wide products in flight
  logic                   v5_r, v6_r;
  logic                   ovl5_r, pvneg5_r, vvz5_r, cz5_r;
  logic                   ovl6_r, pvneg6_r, vvz6_r, cz6_r;
  logic [CW-1:0]          c5_r, c6_r;
  logic [PVW-1:0]         pvm5_r, pvm6_r;
  logic [DW-1:0]          pv2;
  logic [VCW-1:0]         vvc;
  logic                   dneg;

  // the front waits only when its last stage holds an item the queue cannot take
  assign fe       = !qs.full || !v6_r;
  assign in_ready = fe;
  assign push     = v6_r && !qs.full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (fe) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fe) begin
      px1_r <= DPW'(pos_a_x) - DPW'(pos_b_x);
      py1_r <= DPW'(pos_a_y) - DPW'(pos_b_y);
      vx1_r <= DVW'(vel_a_x) - DVW'(vel_b_x);
      vy1_r <= DVW'(vel_a_y) - DVW'(vel_b_y);
      rs1_r <= RSW'(radius_a) + RSW'(radius_b);
    end
  end

  always_comb begin
    sqpx_c = px1_r * px1_r;
    sqpy_c = py1_r * py1_r;
    sqvx_c = vx1_r * vx1_r;
    sqvy_c = vy1_r * vy1_r;
    pvx_c  = px1_r * vx1_r;
    pvy_c  = py1_r * vy1_r;
    rr_c   = rs1_r * rs1_r;
  end

  always_ff @(posedge clk) begin
    if (fe) begin
      sqpx2_r <= sqpx_c[SQPW-1:0];
      sqpy2_r <= sqpy_c[SQPW-1:0];
      sqvx2_r <= sqvx_c[SQVW-1:0];
      sqvy2_r <= sqvy_c[SQVW-1:0];
      pvx2_r  <= pvx_c;
      pvy2_r  <= pvy_c;
      rr2_r   <= rr_c;
    end
  end

  always_ff @(posedge clk) begin
    if (fe) begin
      pp3_r <= PPW'(sqpx2_r) + PPW'(sqpy2_r);
      vv3_r <= VVW'(sqvx2_r) + VVW'(sqvy2_r);
      pv3_r <= pvx2_r + pvy2_r;
      rr3_r <= rr2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fe) begin
      ovl4_r   <= CMPW'(pp3_r) < CMPW'(rr3_r);
      cz4_r    <= CMPW'(pp3_r) == CMPW'(rr3_r);
      c4_r     <= CW'(CMPW'(pp3_r) - CMPW'(rr3_r));
      pvneg4_r <= pv3_r[PVSW-1];
      pvm4_r   <= pv3_r[PVSW-1] ? PVW'(-pv3_r) : PVW'(pv3_r);
      vvz4_r   <= vv3_r == '0;
      vv4_r    <= vv3_r;
    end
  end

  ctc_wmul #(.AW(PVW), .BW(PVW)) u_pv2 (
    .clk (clk),
    .en  (fe),
    .a   (pvm4_r),
    .b   (pvm4_r),
    .p   (pv2)
  );

  ctc_wmul #(.AW(VVW), .BW(CW)) u_vvc (
    .clk (clk),
    .en  (fe),
    .a   (vv4_r),
    .b   (c4_r),
    .p   (vvc)
  );

  always_ff @(posedge clk) begin
    if (fe) begin
      ovl5_r   <= ovl4_r;
      pvneg5_r <= pvneg4_r;
      vvz5_r   <= vvz4_r;
      cz5_r    <= cz4_r;
      c5_r     <= c4_r;
      pvm5_r   <= pvm4_r;
      ovl6_r   <= ovl5_r;
      pvneg6_r <= pvneg5_r;
      vvz6_r   <= vvz5_r;
      cz6_r    <= cz5_r;
      c6_r     <= c5_r;
      pvm6_r   <= pvm5_r;
    end
  end

  assign dneg    = DCW'(pv2) < DCW'(vvc);
  assign cls_d   = DW'(DCW'(pv2) - DCW'(vvc));
  assign cls_pvm = pvm6_r;
  assign cls_c   = c6_r;

  // priority follows the order of the checks: overlap first
  always_comb begin
    cls_go = 1'b0;
    if (ovl6_r) begin
      cls_status = ST_OVERLAP;
    end else if (dneg) begin
      cls_status = ST_MISS;
    end else if (vvz6_r) begin
      cls_status = ST_STILL;
    end else if (cz6_r) begin
      cls_status = ST_HIT;
    end else if (!pvneg6_r) begin
      cls_status = ST_RECEDE;
    end else begin
      cls_status = ST_HIT;
      cls_go     = 1'b1;
    end
  end
endmodule

### sv/ctc_fifo.sv
// short queue between the front and back halves
// depends on ctc_pkg
module ctc_fifo import ctc_pkg::*; #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  input  logic         pop,
  output logic [W-1:0] dout,
  output q_stat_t      qs
);
  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  logic [W-1:0]  mem_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [NW-1:0] cnt_r;

  assign dout     = mem_r[rd_ptr_r];
  assign qs.full  = cnt_r == NW'(QUEUE_DEPTH);
  assign qs.empty = cnt_r == '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end
endmodule

### sv/ctc_back.sv
// back half: pipelined square root of the discriminant, then restoring divide
// depends on ctc_pkg
module ctc_back import ctc_pkg::*; #(
  parameter int POS_WIDTH = POS_WIDTH_DEF,
  parameter int VEL_WIDTH = VEL_WIDTH_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  q_stat_t                               qs,
  output logic                                  pop,
  input  status_t                               hd_status,
  input  logic                                  hd_go,
  input  logic [2*(POS_WIDTH+VEL_WIDTH+1)-1:0]  hd_d,
  input  logic [POS_WIDTH+VEL_WIDTH:0]          hd_pvm,
  input  logic [2*POS_WIDTH:0]                  hd_c,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [TIME_WIDTH-1:0]                 contact_time,
  output status_t                               status
);
  localparam int PVW = POS_WIDTH + VEL_WIDTH + 1;
  localparam int CW  = 2 * POS_WIDTH + 1;
  localparam int DW  = 2 * PVW;
  localparam int DW1 = DW + 1;
  localparam int NS  = PVW;
  localparam int DNW = PVW + 1;
  localparam int NMW = CW + FRAC_BITS;
  localparam int TW  = TIME_WIDTH;
  localparam int XW  = max_int(NMW, DNW + TW) + 1;

  logic be;

  // square root stages, one root bit each
  logic           sr_v_r    [NS];
  logic [DW-1:0]  sr_rem_r  [NS];
  logic [NS-1:0]  sr_root_r [NS];
  status_t        sr_st_r   [NS];
  logic           sr_go_r   [NS];
  logic [PVW-1:0] sr_pvm_r  [NS];
  logic [CW-1:0]  sr_c_r    [NS];

  // denominator stage
  logic           dn_v_r;
  logic [DNW-1:0] dn_den_r;
  logic [NMW-1:0] dn_num_r;
  status_t        dn_st_r;
  logic           dn_go_r;

  // divide stages: the first one tests for saturation, the rest give one bit
  logic           dq_v_r   [TW+1];
  logic [NMW-1:0] dq_num_r [TW+1];
  logic [DNW-1:0] dq_den_r [TW+1];
  logic [TW-1:0]  dq_q_r   [TW+1];
  logic           dq_sat_r [TW+1];
  status_t        dq_st_r  [TW+1];
  logic           dq_go_r  [TW+1];

  assign be  = !dq_v_r[TW] || out_ready;
  assign pop = be && !qs.empty;

  for (genvar k = 0; k < NS; k++) begin : g_sqrt
    localparam int BI = NS - 1 - k;
    logic           v_i, go_i, take;
    logic [DW-1:0]  rem_i;
    logic [NS-1:0]  root_i;
    status_t        st_i;
    logic [PVW-1:0] pvm_i;
    logic [CW-1:0]  c_i;
    logic [DW:0]    trial;

    if (k == 0) begin : g_head
      assign v_i    = !qs.empty;
      assign rem_i  = hd_d;
      assign root_i = '0;
      assign st_i   = hd_status;
      assign go_i   = hd_go;
      assign pvm_i  = hd_pvm;
      assign c_i    = hd_c;
    end else begin : g_prev
      assign v_i    = sr_v_r[k-1];
      assign rem_i  = sr_rem_r[k-1];
      assign root_i = sr_root_r[k-1];
      assign st_i   = sr_st_r[k-1];
      assign go_i   = sr_go_r[k-1];
      assign pvm_i  = sr_pvm_r[k-1];
      assign c_i    = sr_c_r[k-1];
    end

    // (root + 2^bi)^2 - root^2, root holds only bits above bi
    assign trial = (DW1'(root_i) << (BI + 1)) | (DW1'(1) << (2 * BI));
    assign take  = DW1'(rem_i) >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sr_v_r[k] <= 1'b0;
      end else if (be) begin
        sr_v_r[k] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (be) begin
        sr_rem_r[k]  <= take ? rem_i - trial[DW-1:0] : rem_i;
        sr_root_r[k] <= take ? (root_i | (NS'(1) << BI)) : root_i;
        sr_st_r[k]   <= st_i;
        sr_go_r[k]   <= go_i;
        sr_pvm_r[k]  <= pvm_i;
        sr_c_r[k]    <= c_i;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dn_v_r <= 1'b0;
    end else if (be) begin
      dn_v_r <= sr_v_r[NS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (be) begin
      dn_den_r <= DNW'(sr_pvm_r[NS-1]) + DNW'(sr_root_r[NS-1]);
      dn_num_r <= NMW'(sr_c_r[NS-1]) << FRAC_BITS;
      dn_st_r  <= sr_st_r[NS-1];
      dn_go_r  <= sr_go_r[NS-1];
    end
  end

  for (genvar k = 0; k <= TW; k++) begin : g_div
    localparam int B = TW - k;
    logic           v_i, go_i, sat_i, ge;
    logic [NMW-1:0] num_i, num_o;
    logic [DNW-1:0] den_i;
    logic [TW-1:0]  q_i, q_o;
    logic           sat_o;
    status_t        st_i;
    logic [XW-1:0]  dsh;

    if (k == 0) begin : g_head
      assign v_i   = dn_v_r;
      assign num_i = dn_num_r;
      assign den_i = dn_den_r;
      assign q_i   = '0;
      assign sat_i = 1'b0;
      assign st_i  = dn_st_r;
      assign go_i  = dn_go_r;
    end else begin : g_prev
      assign v_i   = dq_v_r[k-1];
      assign num_i = dq_num_r[k-1];
      assign den_i = dq_den_r[k-1];
      assign q_i   = dq_q_r[k-1];
      assign sat_i = dq_sat_r[k-1];
      assign st_i  = dq_st_r[k-1];
      assign go_i  = dq_go_r[k-1];
    end

    assign dsh = XW'(den_i) << B;
    assign ge  = XW'(num_i) >= dsh;

    if (k == 0) begin : g_sat
      assign sat_o = ge;
      assign num_o = num_i;
      assign q_o   = q_i;
    end else begin : g_bit
      assign sat_o = sat_i;
      assign num_o = (!sat_i && ge) ? num_i - dsh[NMW-1:0] : num_i;
      assign q_o   = (!sat_i && ge) ? (q_i | (TW'(1) << B)) : q_i;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dq_v_r[k] <= 1'b0;
      end else if (be) begin
        dq_v_r[k] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (be) begin
        dq_num_r[k] <= num_o;
        dq_den_r[k] <= den_i;
        dq_q_r[k]   <= q_o;
        dq_sat_r[k] <= sat_o;
        dq_st_r[k]  <= st_i;
        dq_go_r[k]  <= go_i;
      end
    end
  end

  assign out_valid    = dq_v_r[TW];
  assign status       = dq_st_r[TW];
  assign contact_time = !dq_go_r[TW] ? '0 : (dq_sat_r[TW] ? '1 : dq_q_r[TW]);
endmodule

### sv/ctc_checker.sv
// port-level checks of the time-to-collision block, bound to the top level
// depends on ctc_pkg and the assertion macros header
`include "circle_time_to_collision_core_macros.svh"

module ctc_checker import ctc_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [TIME_WIDTH-1:0] contact_time,
  input status_t               status
);
  `CTC_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped under stall")
  `CTC_ASSERT(a_time_zero, out_valid && status != ST_HIT |-> contact_time == '0, "time without hit")
  `CTC_ASSERT_RST(a_rst_out, !rst_n |=> !out_valid, "result valid after reset")
  `CTC_ASSERT_RST(a_rst_in, !rst_n |=> in_ready, "input not ready after reset")
endmodule

bind circle_time_to_collision_core ctc_checker u_ctc_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .contact_time (out_ch.contact_time),
  .status       (out_ch.status)
);
